// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Shared assertion macros for the formatter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/ifmt_pkg.sv -----
// ----------------------------------------------------------------------------
// ifmt_pkg
// Shared types and constants for the integer field formatter.
// ----------------------------------------------------------------------------
package ifmt_pkg;

  localparam int FIELD_MAX_DEF = 40;
  localparam int QUEUE_DEPTH   = 2;
  localparam int NDIG          = 22;   // enough for 64-bit octal
  localparam int CW            = 6;    // width / precision counts
  localparam int LW            = 7;    // lengths and positions

  // conversion kinds
  localparam logic [2:0] FUNC_SDEC = 3'd0;
  localparam logic [2:0] FUNC_OCT  = 3'd2;
  localparam logic [2:0] FUNC_HEXL = 3'd3;
  localparam logic [2:0] FUNC_HEXU = 3'd4;

  // length modifiers
  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_H    = 2'd1;

  // flag bit positions
  localparam int FLB_MINUS = 0;
  localparam int FLB_PLUS  = 1;
  localparam int FLB_SPACE = 2;
  localparam int FLB_SHARP = 3;
  localparam int FLB_ZERO  = 4;

  // characters
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_X_LO  = 8'd120;
  localparam logic [7:0] CH_X_UP  = 8'd88;
  localparam logic [7:0] OFS_UP   = 8'd55;
  localparam logic [7:0] OFS_LO   = 8'd87;

  typedef enum logic [1:0] {RAD_DEC, RAD_OCT, RAD_HEX} radix_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [63:0]   mag;
    logic          mag_nz;
    radix_t        radix;
    logic          upper;
    logic [1:0]    npre;
    logic [7:0]    pre0;
    logic [7:0]    pre1;
    logic          oct_sharp;
    logic          minus;
    logic          zfill;
    logic          prec_given;
    logic [CW-1:0] prec;
    logic [CW-1:0] width;
  } desc_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] dz;
    dz = {4'd0, d};
    if (d > 4'd9) return upper ? OFS_UP + dz : OFS_LO + dz;
    return CH_ZERO + dz;
  endfunction

endpackage

// ----- rtl/ifmt_front.sv -----
// ----------------------------------------------------------------------------
// ifmt_front
// Accepts items, truncates the value, takes the magnitude and works out
// sign/prefix, fill mode and saturated width and precision.
// ----------------------------------------------------------------------------
module ifmt_front #(
  parameter int FIELD_MAX = ifmt_pkg::FIELD_MAX_DEF
) (
  input  logic                push,
  output logic                full,
  input  logic [2:0]          func,
  input  logic [63:0]         value,
  input  logic [1:0]          length_mod,
  input  logic [4:0]          flag_bits,
  input  logic [5:0]          field_width,
  input  logic signed [6:0]   digit_precision,
  input  logic                q_full,
  output logic                q_wr,
  output ifmt_pkg::desc_t     q_data
);
  import ifmt_pkg::*;

  logic        is_signed;
  logic [63:0] v;
  logic        neg;
  logic        prec_given;
  logic [5:0]  praw;

  assign full = q_full;
  assign q_wr = push && !q_full;
  assign is_signed = (func == FUNC_SDEC);
  assign prec_given = !digit_precision[6];
  assign praw = digit_precision[5:0];

  // length truncation and sign extension
  always_comb begin
    case (length_mod)
      LEN_H:    v = {{48{is_signed & value[15]}}, value[15:0]};
      LEN_NONE: v = {{32{is_signed & value[31]}}, value[31:0]};
      default:  v = value;
    endcase
  end

  assign neg = is_signed && v[63];

  // classification
  always_comb begin
    q_data = '0;
    q_data.mag = neg ? (~v + 64'd1) : v;
    q_data.mag_nz = (v != 64'd0);
    q_data.upper = (func == FUNC_HEXU);
    case (func)
      FUNC_OCT:  q_data.radix = RAD_OCT;
      FUNC_HEXL: q_data.radix = RAD_HEX;
      FUNC_HEXU: q_data.radix = RAD_HEX;
      default:   q_data.radix = RAD_DEC;
    endcase
    if (is_signed) begin
      if (neg) begin
        q_data.npre = 2'd1;
        q_data.pre0 = CH_MINUS;
      end else if (flag_bits[FLB_PLUS]) begin
        q_data.npre = 2'd1;
        q_data.pre0 = CH_PLUS;
      end else if (flag_bits[FLB_SPACE]) begin
        q_data.npre = 2'd1;
        q_data.pre0 = CH_SPACE;
      end
    end else if (flag_bits[FLB_SHARP]) begin
      if (q_data.radix == RAD_HEX) begin
        q_data.npre = 2'd2;
        q_data.pre0 = CH_ZERO;
        q_data.pre1 = q_data.upper ? CH_X_UP : CH_X_LO;
      end else if (q_data.radix == RAD_OCT) begin
        q_data.oct_sharp = 1'b1;
      end
    end
    q_data.minus = flag_bits[FLB_MINUS];
    q_data.prec_given = prec_given;
    q_data.zfill = flag_bits[FLB_ZERO] && !flag_bits[FLB_MINUS] && !prec_given;
    q_data.prec = !prec_given ? '0 :
                  (praw > CW'(FIELD_MAX)) ? CW'(FIELD_MAX) : praw;
    q_data.width = (field_width > CW'(FIELD_MAX)) ? CW'(FIELD_MAX) : field_width;
  end

endmodule

// ----- rtl/ifmt_fifo.sv -----
// ----------------------------------------------------------------------------
// ifmt_fifo
// Short register queue between the classifier and the character engine.
// ----------------------------------------------------------------------------
module ifmt_fifo #(
  parameter int DEPTH = ifmt_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  ifmt_pkg::desc_t wdata,
  output logic            full,
  input  logic            rd,
  output ifmt_pkg::desc_t rdata,
  output logic            empty
);
  import ifmt_pkg::*;
  `include "assert_macros.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  desc_t          mem [DEPTH];
  logic [AW-1:0]  wptr, rptr;
  logic [NW-1:0]  cnt;
  logic           wr_en, rd_en;

  assign full  = (cnt == NW'(DEPTH));
  assign empty = (cnt == '0);
  assign wr_en = wr && !full;
  assign rd_en = rd && !empty;
  assign rdata = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) mem[wptr] <= wdata;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (wr_en) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      if (rd_en) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      if (wr_en && !rd_en) cnt <= cnt + NW'(1);
      else if (rd_en && !wr_en) cnt <= cnt - NW'(1);
    end
  end

  `ASSERT_IMPL(a_cnt_bound, clk, rst, 1'b1, cnt <= NW'(DEPTH))
  `ASSERT_NEXT(a_cnt_up, clk, rst, wr_en && !rd_en, cnt == $past(cnt) + NW'(1))

endmodule

// ----- rtl/ifmt_back.sv -----
// ----------------------------------------------------------------------------
// ifmt_back
// Character engine: digit conversion (4-bit-per-cycle double dabble for
// decimal), sizing, then one char per cycle while the output register is free.
// ----------------------------------------------------------------------------
module ifmt_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  ifmt_pkg::desc_t q_data,
  output logic            q_rd,
  output logic [7:0]      out_char,
  output logic            last_char,
  output logic            empty,
  input  logic            pop
);
  import ifmt_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE, ST_CONV, ST_COUNT, ST_ZERO, ST_BODY, ST_FILL, ST_BOUND, ST_EMIT
  } state_t;

  state_t              state;
  desc_t               cur;
  logic [NDIG-1:0][3:0] dig;
  logic [NDIG-1:0][3:0] dig_next;
  logic [63:0]         bin;
  logic [63:0]         bin_next;
  logic [3:0]          step;
  logic [4:0]          nd;
  logic [4:0]          nd_next;
  logic [LW-1:0]       zeros, body, pad;
  logic [LW-1:0]       b1, b2, b3, b4, total, pos;
  logic [LW-1:0]       zeros_next, body_fill;
  logic                ovalid;
  logic                fire, is_last;
  logic [7:0]          char_now;
  logic [LW-1:0]       didx;
  logic [NDIG-1:0][3:0] dig_load;

  assign q_rd     = (state == ST_IDLE) && !q_empty;
  assign empty    = !ovalid;
  assign fire     = (state == ST_EMIT) && (!ovalid || pop);
  assign is_last  = (pos == total - LW'(1));

  // direct digit split for octal and hex
  always_comb begin
    dig_load = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (q_data.radix == RAD_HEX) begin
        if (i < 16) dig_load[i] = q_data.mag[4*i +: 4];
      end else begin
        if (i < 21) dig_load[i] = {1'b0, q_data.mag[3*i +: 3]};
        else        dig_load[i] = {3'b000, q_data.mag[63]};
      end
    end
  end

  // four double-dabble steps per cycle
  always_comb begin
    dig_next = dig;
    bin_next = bin;
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < NDIG; i++) begin
        if (dig_next[i] >= 4'd5) dig_next[i] = dig_next[i] + 4'd3;
      end
      {dig_next, bin_next} = {dig_next, bin_next} << 1;
    end
  end

  // significant digit count
  always_comb begin
    nd_next = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (dig[i] != 4'd0) nd_next = 5'(i + 1);
    end
    if (nd_next == '0 && !(cur.prec_given && cur.prec == '0)) nd_next = 5'd1;
  end

  // precision zeros and the octal alternate-form zero
  always_comb begin
    zeros_next = '0;
    if (cur.prec_given && LW'(cur.prec) > LW'(nd)) zeros_next = LW'(cur.prec) - LW'(nd);
    if (cur.oct_sharp && zeros_next == '0 && (cur.mag_nz || nd == '0))
      zeros_next = LW'(1);
  end

  assign body_fill = (cur.zfill && LW'(cur.width) > body) ? LW'(cur.width) : body;

  // character for the current position
  assign didx = b4 - LW'(1) - pos;
  always_comb begin
    if (pos < b1)      char_now = CH_SPACE;
    else if (pos < b2) char_now = (pos == b1) ? cur.pre0 : cur.pre1;
    else if (pos < b3) char_now = CH_ZERO;
    else if (pos < b4) char_now = digit_char(dig[didx[4:0]], cur.upper);
    else               char_now = CH_SPACE;
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ovalid    <= 1'b0;
      out_char  <= '0;
      last_char <= 1'b0;
      step      <= '0;
      pos       <= '0;
    end else begin
      if (pop && ovalid && !fire) ovalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            cur  <= q_data;
            step <= '0;
            if (q_data.radix == RAD_DEC) begin
              dig   <= '0;
              bin   <= q_data.mag;
              state <= ST_CONV;
            end else begin
              dig   <= dig_load;
              state <= ST_COUNT;
            end
          end
        end
        ST_CONV: begin
          dig  <= dig_next;
          bin  <= bin_next;
          step <= step + 4'd1;
          if (step == 4'd15) state <= ST_COUNT;
        end
        ST_COUNT: begin
          nd    <= nd_next;
          state <= ST_ZERO;
        end
        ST_ZERO: begin
          zeros <= zeros_next;
          body  <= LW'(cur.npre) + zeros_next + LW'(nd);
          state <= ST_BODY;
        end
        ST_BODY: begin
          zeros <= zeros + (body_fill - body);
          body  <= body_fill;
          state <= ST_FILL;
        end
        ST_FILL: begin
          pad   <= (LW'(cur.width) > body) ? LW'(cur.width) - body : '0;
          state <= ST_BOUND;
        end
        ST_BOUND: begin
          b1    <= cur.minus ? '0 : pad;
          b2    <= (cur.minus ? '0 : pad) + LW'(cur.npre);
          b3    <= (cur.minus ? '0 : pad) + LW'(cur.npre) + zeros;
          b4    <= (cur.minus ? '0 : pad) + body;
          total <= pad + body;
          pos   <= '0;
          state <= ((pad + body) == '0) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          if (fire) begin
            out_char  <= char_now;
            last_char <= is_last;
            ovalid    <= 1'b1;
            pos       <= pos + LW'(1);
            if (is_last) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_pos_range, clk, rst, state == ST_EMIT, pos < total)
  `ASSERT_NEXT(a_last_idle, clk, rst, fire && is_last, state == ST_IDLE && last_char)

endmodule

// ----- rtl/integer_field_formatter.sv -----
// Octal/hex items pass through five sizing steps (count, zero, body, fill, bound)
// before the first character; decimal items first go through a 4-bit double dabble.
// One character per cycle while emitting, as long as the output register is empty or
// popped; the character engine takes its next item only after an item's last char.
// A two-entry queue lets the next item be accepted while one is emitted.
// Synchronous active-high reset empties the queue and the output register.
// ----------------------------------------------------------------------------
// integer_field_formatter
// printf-style integer conversion, one ASCII character per output word.
// ----------------------------------------------------------------------------
module integer_field_formatter #(
  parameter int FIELD_MAX   = ifmt_pkg::FIELD_MAX_DEF,
  parameter int QUEUE_DEPTH = ifmt_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [2:0]        func,
  input  logic [63:0]       value,
  input  logic [1:0]        length_mod,
  input  logic [4:0]        flag_bits,
  input  logic [5:0]        field_width,
  input  logic signed [6:0] digit_precision,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_char,
  output logic              last_char
);
  import ifmt_pkg::*;

  desc_t wdata, rdata;
  logic  q_wr, q_full, q_rd, q_empty;

  ifmt_front #(.FIELD_MAX(FIELD_MAX)) u_front (
    .push(push), .full(full), .func(func), .value(value),
    .length_mod(length_mod), .flag_bits(flag_bits),
    .field_width(field_width), .digit_precision(digit_precision),
    .q_full(q_full), .q_wr(q_wr), .q_data(wdata)
  );

  ifmt_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst(rst), .wr(q_wr), .wdata(wdata), .full(q_full),
    .rd(q_rd), .rdata(rdata), .empty(q_empty)
  );

  ifmt_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_data(rdata), .q_rd(q_rd),
    .out_char(out_char), .last_char(last_char), .empty(empty), .pop(pop)
  );

endmodule
